[hw/rtl/tbc_pkg.sv]
`timescale 1ns / 1ps

package tbc_pkg;

	localparam int TIMER_BITS_DEF = 18;

	localparam int CFG_ADDR_BITS = 5;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 8;

	localparam logic [7:0] STABLE_MAX = 8'hFF;

	typedef enum logic [4:0] {
		ST_BOOT    = 5'b00000,
		ST_ARMED   = 5'b00001,
		ST_PROT    = 5'b00010,
		ST_RELEASE = 5'b00100,
		ST_CLEAN   = 5'b01000,
		ST_CAPT    = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		REG_FRAME_INTERVAL = 3'd0,
		REG_BOOT_FRAMES    = 3'd1,
		REG_RESTART_NODES  = 3'd2,
		REG_QUIET_NODES    = 3'd3,
		REG_RELEASE_WINDOW = 3'd4,
		REG_CLEAN_WAIT     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] frame_period_ms;
		logic [7:0]  bootstrap_frames;
		logic [15:0] activity_restart_nodes;
		logic [15:0] quiet_nodes;
		logic [15:0] release_window_ms;
		logic [15:0] clean_wait_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		frame_period_ms:        16'd16,
		bootstrap_frames:       8'd5,
		activity_restart_nodes: 16'd30,
		quiet_nodes:            16'd1,
		release_window_ms:      16'd333,
		clean_wait_ms:          16'd100
	};

	typedef struct packed {
		logic        hard_reset;
		logic        screen_on_frame;
		logic        guard_active;
		logic [15:0] busy_nodes;
	} frame_t;

endpackage

[hw/rtl/tbc_step.sv]
`timescale 1ns / 1ps

module tbc_step
	import tbc_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  cfg_t                  cfg,
	input  frame_t                frame,
	input  state_t                state,
	input  logic [7:0]            stable_count,
	input  logic [TIMER_BITS-1:0] elapsed_ms,
	input  logic                  ready_flag,
	input  logic                  captured_flag,
	output state_t                state_nxt,
	output logic [7:0]            stable_count_nxt,
	output logic [TIMER_BITS-1:0] elapsed_ms_nxt,
	output logic                  ready_flag_nxt,
	output logic                  captured_flag_nxt,
	output logic                  capture_pulse
);

	logic [15:0]           step_ms;
	logic [TIMER_BITS:0]   timer_sum;
	logic [TIMER_BITS-1:0] timer_adv;
	logic                  over_release;
	logic                  over_clean;
	logic                  busy_frame;
	logic                  quiet_frame;

	assign step_ms = (cfg.frame_period_ms == 16'd0) ? 16'd1 : cfg.frame_period_ms;
	assign timer_sum = {1'b0, elapsed_ms} + (TIMER_BITS + 1)'(step_ms);
	assign timer_adv = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
	assign over_release = elapsed_ms > TIMER_BITS'(cfg.release_window_ms);
	assign over_clean = elapsed_ms > TIMER_BITS'(cfg.clean_wait_ms);
	assign busy_frame = frame.busy_nodes > cfg.activity_restart_nodes;
	assign quiet_frame = frame.busy_nodes <= cfg.quiet_nodes;

	always_comb begin
		state_nxt = state;
		stable_count_nxt = stable_count;
		elapsed_ms_nxt = elapsed_ms;
		ready_flag_nxt = ready_flag;
		captured_flag_nxt = captured_flag;
		capture_pulse = 1'b0;
		if (frame.hard_reset || frame.screen_on_frame) begin
			state_nxt = ST_BOOT;
			stable_count_nxt = 8'd0;
			elapsed_ms_nxt = '0;
			ready_flag_nxt = 1'b0;
			captured_flag_nxt = 1'b0;
		end else begin
			unique case (state)
				ST_BOOT: begin
					if (stable_count > cfg.bootstrap_frames) begin
						state_nxt = ST_ARMED;
						elapsed_ms_nxt = '0;
						stable_count_nxt = 8'd0;
					end else if (stable_count != STABLE_MAX) begin
						stable_count_nxt = stable_count + 8'd1;
					end
				end
				ST_ARMED: begin
					if (frame.guard_active) begin
						state_nxt = ST_PROT;
						elapsed_ms_nxt = '0;
					end
				end
				ST_PROT: begin
					if (!frame.guard_active) begin
						state_nxt = ST_RELEASE;
						elapsed_ms_nxt = '0;
					end
				end
				ST_RELEASE: begin
					if (frame.guard_active) begin
						state_nxt = ST_PROT;
						elapsed_ms_nxt = '0;
					end else if (busy_frame || over_release) begin
						ready_flag_nxt = 1'b1;
						state_nxt = ST_ARMED;
						elapsed_ms_nxt = '0;
					end else if (quiet_frame) begin
						state_nxt = ST_CLEAN;
						elapsed_ms_nxt = '0;
					end else begin
						elapsed_ms_nxt = timer_adv;
					end
				end
				ST_CLEAN: begin
					if (frame.guard_active) begin
						state_nxt = ST_PROT;
						elapsed_ms_nxt = '0;
					end else if (over_clean) begin
						ready_flag_nxt = 1'b0;
						state_nxt = ST_CAPT;
						captured_flag_nxt = 1'b1;
						capture_pulse = 1'b1;
					end else if (quiet_frame) begin
						elapsed_ms_nxt = timer_adv;
					end else begin
						ready_flag_nxt = 1'b1;
						state_nxt = ST_ARMED;
						elapsed_ms_nxt = '0;
					end
				end
				default: begin
					state_nxt = state;
				end
			endcase
		end
	end

endmodule

[hw/rtl/touch_baseline_capture_fsm.sv]
`timescale 1ns / 1ps

// Baseline-capture state machine for a touch controller, stepped once per frame.
// Each slave-side stream transaction carries one frame summary; each master-side
// transaction returns the machine state, the ready and captured flags and the
// capture pulse after that frame's update.
// A frame is registered in the input register on acceptance, and its result is
// registered in the result register when the frame advances, which it does
// only while the result register is empty or being drained.
// The state update is a single compare-and-add step, so one frame is accepted
// every cycle while the output side keeps up.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more frame; s_axis_tready then falls until the
// output register is drained.
// The APB port sets the six timing and threshold registers; the user is to write
// them only while no frame is in flight, which the block itself does not enforce.
// Reset clears the pipeline, returns the machine to bootstrap with all counters
// and flags cleared, and loads the registers with their default values.

module touch_baseline_capture_fsm
	import tbc_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// hard_reset, screen_on_frame, guard_active, busy_nodes[15:0], zero pad
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,

	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// machine_state[4:0], normal_ready, clean_captured, capture_pulse
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	cfg_t                  cfg_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	logic                  valid_s1;
	frame_t                frame_s1;
	logic                  valid_s2;
	logic [OUT_DATA_BITS-1:0] result_s2;
	logic                  advance;

	state_t                state_q;
	logic [7:0]            stable_count_q;
	logic [TIMER_BITS-1:0] elapsed_ms_q;
	logic                  ready_flag_q;
	logic                  captured_flag_q;

	state_t                state_nxt;
	logic [7:0]            stable_count_nxt;
	logic [TIMER_BITS-1:0] elapsed_ms_nxt;
	logic                  ready_flag_nxt;
	logic                  captured_flag_nxt;
	logic                  capture_pulse;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_INTERVAL: cfg_q.frame_period_ms <= pwdata[15:0];
				REG_BOOT_FRAMES:    cfg_q.bootstrap_frames <= pwdata[7:0];
				REG_RESTART_NODES:  cfg_q.activity_restart_nodes <= pwdata[15:0];
				REG_QUIET_NODES:    cfg_q.quiet_nodes <= pwdata[15:0];
				REG_RELEASE_WINDOW: cfg_q.release_window_ms <= pwdata[15:0];
				REG_CLEAN_WAIT:     cfg_q.clean_wait_ms <= pwdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_INTERVAL: prdata = {16'd0, cfg_q.frame_period_ms};
			REG_BOOT_FRAMES:    prdata = {24'd0, cfg_q.bootstrap_frames};
			REG_RESTART_NODES:  prdata = {16'd0, cfg_q.activity_restart_nodes};
			REG_QUIET_NODES:    prdata = {16'd0, cfg_q.quiet_nodes};
			REG_RELEASE_WINDOW: prdata = {16'd0, cfg_q.release_window_ms};
			REG_CLEAN_WAIT:     prdata = {16'd0, cfg_q.clean_wait_ms};
			default:            prdata = 32'd0;
		endcase
	end

	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			frame_s1 <= '{
				hard_reset:      s_axis_tdata[0],
				screen_on_frame: s_axis_tdata[1],
				guard_active:    s_axis_tdata[2],
				busy_nodes:      s_axis_tdata[18:3]
			};
		end
	end

	tbc_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.cfg               (cfg_q),
		.frame             (frame_s1),
		.state             (state_q),
		.stable_count      (stable_count_q),
		.elapsed_ms        (elapsed_ms_q),
		.ready_flag        (ready_flag_q),
		.captured_flag     (captured_flag_q),
		.state_nxt         (state_nxt),
		.stable_count_nxt  (stable_count_nxt),
		.elapsed_ms_nxt    (elapsed_ms_nxt),
		.ready_flag_nxt    (ready_flag_nxt),
		.captured_flag_nxt (captured_flag_nxt),
		.capture_pulse     (capture_pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
			stable_count_q <= 8'd0;
			elapsed_ms_q <= '0;
			ready_flag_q <= 1'b0;
			captured_flag_q <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			stable_count_q <= stable_count_nxt;
			elapsed_ms_q <= elapsed_ms_nxt;
			ready_flag_q <= ready_flag_nxt;
			captured_flag_q <= captured_flag_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= {capture_pulse, captured_flag_nxt, ready_flag_nxt, state_nxt};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = result_s2;

endmodule
